[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for concurrent assertions clocked on a rising edge.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while reset is released.
`define PIC_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("pic assertion failed");

// Checked at every edge, reset included.
`define PIC_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("pic assertion failed");

`endif

[rtl/pic_pkg.sv]
// ----------------------------------------------------------------------------
// pic_pkg
// Types and constants for the eight-line priority interrupt controller.
// ----------------------------------------------------------------------------
package pic_pkg;

  localparam int LINE_COUNT = 8;
  localparam int LINE_W     = 3;
  localparam int ACT_W      = 3;
  localparam int ADDR_W     = 8;
  localparam int DATA_W     = 8;
  localparam int VEC_W      = 11;

  typedef logic [ACT_W-1:0]      act_t;
  typedef logic [LINE_COUNT-1:0] line_mask_t;
  typedef logic [LINE_W-1:0]     line_t;
  typedef logic [ADDR_W-1:0]     addr_t;
  typedef logic [DATA_W-1:0]     data_t;
  typedef logic [VEC_W-1:0]      vec_t;

  // Action codes
  localparam act_t ACT_LINE_CHANGE = 3'd0;
  localparam act_t ACT_SW_RAISE    = 3'd1;
  localparam act_t ACT_REG_WRITE   = 3'd2;
  localparam act_t ACT_REG_READ    = 3'd3;
  localparam act_t ACT_POLL        = 3'd4;

  // Register addresses
  localparam addr_t ADDR_VECTOR_BASE = 8'hB0;
  localparam addr_t ADDR_ENABLE      = 8'hB2;
  localparam addr_t ADDR_STATUS      = 8'hB6;

endpackage

[rtl/priority_interrupt_controller_unit.sv]
// ----------------------------------------------------------------------------
// priority_interrupt_controller_unit
// Eight-line priority interrupt controller with a register port and poll.
// ----------------------------------------------------------------------------
// Takes one item per clock while the result side does not stall and returns
// one result per item via the input register, then the result register.
// The whole state update of an item - line edge detect, pending latch,
// register access and the eight-bit priority encode of the winner - is one
// combinational step between those two registers, so throughput is one item
// per cycle whenever the result side does not stall. The level-trigger mask
// is set via cfg_we and applies at the next item that re-evaluates the winner.
module priority_interrupt_controller_unit (
  input  logic                   clk,
  input  logic                   rst_n,
  // configuration
  input  logic                   cfg_we,
  input  pic_pkg::line_mask_t    cfg_wdata,
  // input channel
  input  logic                   in_valid,
  output logic                   in_stall,
  input  pic_pkg::act_t          in_action,
  input  pic_pkg::line_t         in_line_index,
  input  logic                   in_line_level,
  input  pic_pkg::addr_t         in_reg_addr,
  input  pic_pkg::data_t         in_write_data,
  // result channel
  output logic                   out_valid,
  input  logic                   out_stall,
  output pic_pkg::data_t         out_read_data,
  output logic                   out_irq_pending,
  output pic_pkg::line_t         out_irq_line,
  output pic_pkg::vec_t          out_irq_vector,
  output logic                   out_irq_take
);

  import pic_pkg::*;

  // Input register
  logic       in_v_r;
  act_t       act_r;
  line_t      line_r;
  logic       level_r;
  addr_t      addr_r;
  data_t      wdata_r;

  // Controller state
  line_mask_t ltm_r;
  line_mask_t levels_r,  levels_nxt;
  line_mask_t pending_r, pending_nxt;
  line_mask_t enable_r,  enable_nxt;
  data_t      base_r,    base_nxt;
  logic       win_v_r,   win_v_nxt;
  line_t      win_line_r, win_line_nxt;
  vec_t       win_vec_r, win_vec_nxt;

  // Result register
  logic       out_v_r;
  data_t      rd_r,   rd_nxt;
  logic       take_r, take_nxt;

  logic       advance;
  logic       reeval;
  line_mask_t line_bit;
  line_mask_t active;
  logic [DATA_W:0] vec_sum;

  assign advance  = in_v_r && (!out_v_r || !out_stall);
  assign in_stall = in_v_r && !advance;
  assign line_bit = line_mask_t'(1) << line_r;

  always_comb begin
    levels_nxt  = levels_r;
    pending_nxt = pending_r;
    enable_nxt  = enable_r;
    base_nxt    = base_r;
    rd_nxt      = '0;
    take_nxt    = 1'b0;
    reeval      = 1'b0;

    case (act_r)
      ACT_LINE_CHANGE: begin
        levels_nxt  = level_r ? (levels_r | line_bit) : (levels_r & ~line_bit);
        // latch only on a rising edge of an enabled line
        pending_nxt = pending_r | ((levels_r ^ levels_nxt) & levels_nxt & enable_r);
        reeval      = 1'b1;
      end
      ACT_SW_RAISE: begin
        pending_nxt = pending_r | (line_bit & enable_r);
        reeval      = 1'b1;
      end
      ACT_REG_WRITE: begin
        case (addr_r)
          ADDR_VECTOR_BASE: begin
            base_nxt = wdata_r;
            reeval   = 1'b1;
          end
          ADDR_ENABLE: begin
            enable_nxt  = wdata_r;
            pending_nxt = pending_r & wdata_r;
            reeval      = 1'b1;
          end
          ADDR_STATUS: begin
            pending_nxt = pending_r & ~wdata_r;
            reeval      = 1'b1;
          end
          default: ;
        endcase
      end
      ACT_REG_READ: begin
        case (addr_r)
          ADDR_VECTOR_BASE: rd_nxt = base_r;
          ADDR_ENABLE:      rd_nxt = enable_r;
          ADDR_STATUS:      rd_nxt = data_t'(1) << win_line_r;
          default:          rd_nxt = '0;
        endcase
      end
      ACT_POLL: take_nxt = win_v_r;
      default: ;
    endcase

    // Level-triggered lines latch at every re-evaluation
    if (reeval) begin
      pending_nxt = pending_nxt | (levels_nxt & ltm_r & enable_nxt);
    end
    active = pending_nxt & enable_nxt;
  end

  // Lowest-numbered active line wins
  always_comb begin
    win_line_nxt = win_line_r;
    win_v_nxt    = win_v_r;
    if (reeval) begin
      win_v_nxt    = |active;
      win_line_nxt = '0;
      for (int i = LINE_COUNT - 1; i >= 0; i--) begin
        if (active[i]) begin
          win_line_nxt = line_t'(i);
        end
      end
    end
    vec_sum = {1'b0, base_nxt} + (DATA_W + 1)'(win_line_nxt);
  end

  always_comb begin
    win_vec_nxt = win_vec_r;
    if (reeval) begin
      win_vec_nxt = win_v_nxt ? {vec_sum, 2'b00} : '0;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r     <= 1'b0;
      out_v_r    <= 1'b0;
      ltm_r      <= '0;
      levels_r   <= '0;
      pending_r  <= '0;
      enable_r   <= '0;
      base_r     <= '0;
      win_v_r    <= 1'b0;
      win_line_r <= '0;
      win_vec_r  <= '0;
    end else begin
      if (cfg_we) begin
        ltm_r <= cfg_wdata;
      end
      if (!in_stall) begin
        in_v_r <= in_valid;
      end
      if (advance) begin
        out_v_r    <= 1'b1;
        levels_r   <= levels_nxt;
        pending_r  <= pending_nxt;
        enable_r   <= enable_nxt;
        base_r     <= base_nxt;
        win_v_r    <= win_v_nxt;
        win_line_r <= win_line_nxt;
        win_vec_r  <= win_vec_nxt;
      end else if (!out_stall) begin
        out_v_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (!in_stall) begin
      act_r   <= in_action;
      line_r  <= in_line_index;
      level_r <= in_line_level;
      addr_r  <= in_reg_addr;
      wdata_r <= in_write_data;
    end
    if (advance) begin
      rd_r   <= rd_nxt;
      take_r <= take_nxt;
    end
  end

  assign out_valid       = out_v_r;
  assign out_read_data   = rd_r;
  assign out_irq_pending = win_v_r;
  assign out_irq_line    = win_line_r;
  assign out_irq_vector  = win_vec_r;
  assign out_irq_take    = take_r;

endmodule

[rtl/pic_checker.sv]
// ----------------------------------------------------------------------------
// pic_checker
// Port-level checks for the priority interrupt controller.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pic_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                out_valid,
  input  logic                out_stall,
  input  pic_pkg::data_t      out_read_data,
  input  logic                out_irq_pending,
  input  pic_pkg::line_t      out_irq_line,
  input  pic_pkg::vec_t       out_irq_vector,
  input  logic                out_irq_take
);

  import pic_pkg::*;

  // No winner reports line zero and vector zero
  `PIC_ASSERT(a_idle_winner_zero, clk, rst_n, (out_valid && !out_irq_pending) |-> (out_irq_line == '0 && out_irq_vector == '0))

  // A poll can only deliver an interrupt that is pending
  `PIC_ASSERT(a_take_needs_pending, clk, rst_n, (out_valid && out_irq_take) |-> out_irq_pending)

  // Vectors are scaled by four
  `PIC_ASSERT(a_vector_aligned, clk, rst_n, out_valid |-> (out_irq_vector[1:0] == 2'b00))

  // Hold a stalled result transfer
  `PIC_ASSERT(a_out_hold, clk, rst_n, (out_valid && out_stall) |=> (out_valid && $stable(out_read_data) && $stable(out_irq_take)))

endmodule

bind priority_interrupt_controller_unit pic_checker u_pic_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_read_data   (out_read_data),
  .out_irq_pending (out_irq_pending),
  .out_irq_line    (out_irq_line),
  .out_irq_vector  (out_irq_vector),
  .out_irq_take    (out_irq_take)
);
